// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/clr_pkg.sv =====
package clr_pkg;

    localparam int GRID_CELLS_DEF      = 64;
    localparam int CELL_WIDTH_SUB_DEF  = 2;
    localparam int CELL_HEIGHT_SUB_DEF = 4;

    localparam int SUB_X_W    = 7;
    localparam int SUB_Y_W    = 8;
    localparam int CELL_W     = 6;
    localparam int GLYPH_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Scaled sub-pixel magnitudes: up to 255*2 + 127*4 fits in 12 bits
    localparam int MAG_W = 12;

    // Reciprocal multiply for the sub-pixel to cell division
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_ROWS = 1'b1;

    localparam logic [CFG_DATA_W-1:0] VISIBLE_COLS_RST = 7'd64;
    localparam logic [CFG_DATA_W-1:0] VISIBLE_ROWS_RST = 7'd63;

    localparam logic [GLYPH_W-1:0] GLYPH_FLAT      = 2'd0;
    localparam logic [GLYPH_W-1:0] GLYPH_UPRIGHT   = 2'd1;
    localparam logic [GLYPH_W-1:0] GLYPH_BACKSLASH = 2'd2;
    localparam logic [GLYPH_W-1:0] GLYPH_SLASH     = 2'd3;

endpackage

// ===== rtl/clipped_line_rasterizer_unit.sv =====
// An accepted request passes through ST_SQ_B, ST_SQ_SUM and ST_SQ_DIFF into ST_WALK, which
// loads the first cell into the output register; a new segment is taken only in ST_IDLE. One cell
// per cycle while the walker runs and m_ready does not stall it, set by the single Bresenham step unit.
// The slant glyph takes three passes through one shared squaring multiplier.
// Reset (aresetn low, synchronous) idles the walker, drops m_valid and restores
// visible_cols = 64, visible_rows = 63.
module clipped_line_rasterizer_unit #(
    parameter int GRID_CELLS      = clr_pkg::GRID_CELLS_DEF,
    parameter int CELL_WIDTH_SUB  = clr_pkg::CELL_WIDTH_SUB_DEF,
    parameter int CELL_HEIGHT_SUB = clr_pkg::CELL_HEIGHT_SUB_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [clr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [clr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [clr_pkg::SUB_X_W-1:0]     s_start_x_sub,
    input  logic [clr_pkg::SUB_Y_W-1:0]     s_start_y_sub,
    input  logic [clr_pkg::SUB_X_W-1:0]     s_end_x_sub,
    input  logic [clr_pkg::SUB_Y_W-1:0]     s_end_y_sub,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [clr_pkg::CELL_W-1:0]      m_cell_x,
    output logic [clr_pkg::CELL_W-1:0]      m_cell_y,
    output logic                            m_visible,
    output logic [clr_pkg::GLYPH_W-1:0]     m_glyph,
    output logic                            m_last
);
    import clr_pkg::*;

    localparam int CW       = $clog2(GRID_CELLS);
    localparam int EW       = CW + 2;
    localparam int QW       = SUB_Y_W + 1;
    localparam int CELL_MAX = GRID_CELLS - 1;
    localparam int RECIP_X  = (2**RECIP_SHIFT + CELL_WIDTH_SUB - 1) / CELL_WIDTH_SUB;
    localparam int RECIP_Y  = (2**RECIP_SHIFT + CELL_HEIGHT_SUB - 1) / CELL_HEIGHT_SUB;
    localparam int PXW      = SUB_X_W + RECIP_W;
    localparam int PYW      = SUB_Y_W + RECIP_W;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SQ_B    = 5'b00010,
        ST_SQ_SUM  = 5'b00100,
        ST_SQ_DIFF = 5'b01000,
        ST_WALK    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] vis_cols_reg, vis_rows_reg;

    logic [CW-1:0]          cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [CW-1:0]          goal_x_reg, goal_x_next, goal_y_reg, goal_y_next;
    logic [CW-1:0]          abs_dx_reg, abs_dx_next;
    logic signed [CW:0]     neg_abs_dy_reg, neg_abs_dy_next;
    logic signed [EW-1:0]   step_err_reg, step_err_next;
    logic                   step_x_neg_reg, step_x_neg_next;
    logic                   step_y_neg_reg, step_y_neg_next;
    logic [GLYPH_W-1:0]     line_glyph_reg, line_glyph_next;

    logic [MAG_W-1:0]       a_reg, a_next, b_reg, b_next;
    logic                   same_sign_reg, same_sign_next;
    logic                   flat_reg, flat_next;
    logic [2*MAG_W-1:0]     b2_reg, b2_next;

    logic                   m_valid_reg, m_valid_next;
    logic [CELL_W-1:0]      m_cell_x_reg, m_cell_x_next, m_cell_y_reg, m_cell_y_next;
    logic                   m_visible_reg, m_visible_next;
    logic [GLYPH_W-1:0]     m_glyph_reg, m_glyph_next;
    logic                   m_last_reg, m_last_next;

    // sub-pixel to cell conversion
    logic [PXW-1:0] sx_prod, ex_prod;
    logic [PYW-1:0] sy_prod, ey_prod;
    logic [CW-1:0]  sx_cell, sy_cell, ex_cell, ey_cell;

    // scaled sub-pixel deltas for the glyph
    logic                 dx_neg, dy_neg;
    logic [SUB_X_W-1:0]   adx_sub;
    logic [SUB_Y_W-1:0]   ady_sub;

    // shared squaring unit
    logic [MAG_W-1:0]     sq_op;
    logic [2*MAG_W-1:0]   sq;
    logic [2*MAG_W:0]     twice_b2;

    // walker step unit
    logic                 at_goal;
    logic                 emit;
    logic signed [EW:0]   e2, ndy_ext, adx_ext;
    logic                 x_step, y_step;
    logic signed [EW-1:0] err_add_x, err_add_y;

    function automatic logic [CW-1:0] sat_cell(input logic [QW-1:0] q);
        if (q > QW'(CELL_MAX)) begin
            return CW'(CELL_MAX);
        end
        return q[CW-1:0];
    endfunction

    assign sx_prod = PXW'(s_start_x_sub) * PXW'(RECIP_X);
    assign ex_prod = PXW'(s_end_x_sub) * PXW'(RECIP_X);
    assign sy_prod = PYW'(s_start_y_sub) * PYW'(RECIP_Y);
    assign ey_prod = PYW'(s_end_y_sub) * PYW'(RECIP_Y);

    assign sx_cell = sat_cell(QW'(sx_prod[PXW-1:RECIP_SHIFT]));
    assign ex_cell = sat_cell(QW'(ex_prod[PXW-1:RECIP_SHIFT]));
    assign sy_cell = sat_cell(QW'(sy_prod[PYW-1:RECIP_SHIFT]));
    assign ey_cell = sat_cell(QW'(ey_prod[PYW-1:RECIP_SHIFT]));

    assign dx_neg  = s_end_x_sub < s_start_x_sub;
    assign dy_neg  = s_end_y_sub < s_start_y_sub;
    assign adx_sub = dx_neg ? s_start_x_sub - s_end_x_sub : s_end_x_sub - s_start_x_sub;
    assign ady_sub = dy_neg ? s_start_y_sub - s_end_y_sub : s_end_y_sub - s_start_y_sub;

    always_comb begin
        unique case (state_reg)
            ST_SQ_SUM:  sq_op = a_reg + b_reg;
            ST_SQ_DIFF: sq_op = a_reg - b_reg;
            default:    sq_op = b_reg;
        endcase
    end

    assign sq       = (2*MAG_W)'(sq_op) * (2*MAG_W)'(sq_op);
    assign twice_b2 = {b2_reg, 1'b0};

    assign at_goal   = (cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg);
    assign emit      = !m_valid_reg || m_ready;
    assign e2        = {step_err_reg, 1'b0};
    assign ndy_ext   = (EW+1)'(neg_abs_dy_reg);
    assign adx_ext   = signed'((EW+1)'(abs_dx_reg));
    assign x_step    = e2 >= ndy_ext;
    assign y_step    = e2 <= adx_ext;
    assign err_add_x = x_step ? EW'(neg_abs_dy_reg) : '0;
    assign err_add_y = y_step ? signed'(EW'(abs_dx_reg)) : '0;

    always_comb begin
        state_next      = state_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        goal_x_next     = goal_x_reg;
        goal_y_next     = goal_y_reg;
        abs_dx_next     = abs_dx_reg;
        neg_abs_dy_next = neg_abs_dy_reg;
        step_err_next   = step_err_reg;
        step_x_neg_next = step_x_neg_reg;
        step_y_neg_next = step_y_neg_reg;
        line_glyph_next = line_glyph_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        same_sign_next  = same_sign_reg;
        flat_next       = flat_reg;
        b2_next         = b2_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_cell_x_next   = m_cell_x_reg;
        m_cell_y_next   = m_cell_y_reg;
        m_visible_next  = m_visible_reg;
        m_glyph_next    = m_glyph_reg;
        m_last_next     = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cur_x_next      = sx_cell;
                    cur_y_next      = sy_cell;
                    goal_x_next     = ex_cell;
                    goal_y_next     = ey_cell;
                    abs_dx_next     = (ex_cell > sx_cell) ? ex_cell - sx_cell
                                                          : sx_cell - ex_cell;
                    neg_abs_dy_next = -signed'((CW+1)'((ey_cell > sy_cell)
                                                       ? ey_cell - sy_cell
                                                       : sy_cell - ey_cell));
                    step_x_neg_next = !(sx_cell < ex_cell);
                    step_y_neg_next = !(sy_cell < ey_cell);
                    a_next          = MAG_W'(ady_sub) * MAG_W'(CELL_WIDTH_SUB);
                    b_next          = MAG_W'(adx_sub) * MAG_W'(CELL_HEIGHT_SUB);
                    same_sign_next  = (dx_neg == dy_neg);
                    state_next      = ST_SQ_B;
                end
            end
            ST_SQ_B: begin
                b2_next       = sq;
                step_err_next = signed'(EW'(abs_dx_reg)) + EW'(neg_abs_dy_reg);
                state_next    = ST_SQ_SUM;
            end
            ST_SQ_SUM: begin
                flat_next  = {1'b0, sq} < twice_b2;
                state_next = ST_SQ_DIFF;
            end
            ST_SQ_DIFF: begin
                priority if (((a_reg == '0) && (b_reg == '0)) || flat_reg) begin
                    line_glyph_next = GLYPH_FLAT;
                end else if ((a_reg > b_reg) && ({1'b0, sq} > twice_b2)) begin
                    line_glyph_next = GLYPH_UPRIGHT;
                end else begin
                    line_glyph_next = same_sign_reg ? GLYPH_BACKSLASH : GLYPH_SLASH;
                end
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (emit) begin
                    m_valid_next   = 1'b1;
                    m_cell_x_next  = CELL_W'(cur_x_reg);
                    m_cell_y_next  = CELL_W'(cur_y_reg);
                    m_visible_next = (CFG_DATA_W'(cur_x_reg) < vis_cols_reg) &&
                                     (CFG_DATA_W'(cur_y_reg) < vis_rows_reg);
                    m_glyph_next   = line_glyph_reg;
                    m_last_next    = at_goal;
                    if (at_goal) begin
                        state_next = ST_IDLE;
                    end else begin
                        step_err_next = step_err_reg + err_add_x + err_add_y;
                        if (x_step) begin
                            cur_x_next = step_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                        end
                        if (y_step) begin
                            cur_y_next = step_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            vis_cols_reg   <= VISIBLE_COLS_RST;
            vis_rows_reg   <= VISIBLE_ROWS_RST;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            abs_dx_reg     <= '0;
            neg_abs_dy_reg <= '0;
            step_err_reg   <= '0;
            step_x_neg_reg <= 1'b0;
            step_y_neg_reg <= 1'b0;
            line_glyph_reg <= GLYPH_FLAT;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            goal_x_reg     <= goal_x_next;
            goal_y_reg     <= goal_y_next;
            abs_dx_reg     <= abs_dx_next;
            neg_abs_dy_reg <= neg_abs_dy_next;
            step_err_reg   <= step_err_next;
            step_x_neg_reg <= step_x_neg_next;
            step_y_neg_reg <= step_y_neg_next;
            line_glyph_reg <= line_glyph_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_VISIBLE_COLS: vis_cols_reg <= cfg_wdata;
                    REG_VISIBLE_ROWS: vis_rows_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // glyph scratch and output payload
    always_ff @(posedge aclk) begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        same_sign_reg <= same_sign_next;
        flat_reg      <= flat_next;
        b2_reg        <= b2_next;
        m_cell_x_reg  <= m_cell_x_next;
        m_cell_y_reg  <= m_cell_y_next;
        m_visible_reg <= m_visible_next;
        m_glyph_reg   <= m_glyph_next;
        m_last_reg    <= m_last_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_cell_x  = m_cell_x_reg;
    assign m_cell_y  = m_cell_y_reg;
    assign m_visible = m_visible_reg;
    assign m_glyph   = m_glyph_reg;
    assign m_last    = m_last_reg;

endmodule

// ===== rtl/clr_checker.sv =====
`include "assert_macros.svh"

module clr_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [clr_pkg::CELL_W-1:0]  m_cell_x,
    input logic [clr_pkg::CELL_W-1:0]  m_cell_y,
    input logic [clr_pkg::GLYPH_W-1:0] m_glyph,
    input logic                        m_last
);
    import clr_pkg::*;

    // a stalled result keeps its cell
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_cell_x) && $stable(m_cell_y) && $stable(m_glyph) && $stable(m_last), "stalled result changed")

    // a request starts the glyph passes, so no back-to-back accept
    `ASSERT_NEXT(a_busy_after_req, aclk, aresetn, s_valid && s_ready, !s_ready, "request taken while busy")

    // no new request while a line is still being emitted
    `ASSERT_IMPLIES(a_no_req_mid_line, aclk, aresetn, m_valid && !m_last, !s_ready, "ready before last cell")

    // the walker refills the output slot as soon as a non-final cell leaves
    `ASSERT_NEXT(a_cell_follows, aclk, aresetn, m_valid && m_ready && !m_last, m_valid, "gap inside a line")

endmodule

bind clipped_line_rasterizer_unit clr_checker u_clr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_cell_x (m_cell_x),
    .m_cell_y (m_cell_y),
    .m_glyph  (m_glyph),
    .m_last   (m_last)
);

// ===== test/line_walk_checker.sv =====
module line_walk_checker
    import clr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [SUB_X_W-1:0]    s_start_x_sub,
    input  logic [SUB_Y_W-1:0]    s_start_y_sub,
    input  logic [SUB_X_W-1:0]    s_end_x_sub,
    input  logic [SUB_Y_W-1:0]    s_end_y_sub,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [CELL_W-1:0]     m_cell_x,
    input  logic [CELL_W-1:0]     m_cell_y,
    input  logic                  m_visible,
    input  logic [GLYPH_W-1:0]    m_glyph,
    input  logic                  m_last,
    output int                    mismatch_count,
    output int                    cells_outstanding
);

    typedef struct packed {
        logic [CELL_W-1:0]  cell_x;
        logic [CELL_W-1:0]  cell_y;
        logic               visible;
        logic [GLYPH_W-1:0] glyph;
        logic               last;
    } line_cell_t;

    line_cell_t            cells_due[$];
    logic [CFG_DATA_W-1:0] area_cols;
    logic [CFG_DATA_W-1:0] area_rows;

    function automatic logic [GLYPH_W-1:0] slant_of(int dx, int dy);
        longint a;
        longint b;
        a = longint'(dy < 0 ? -dy : dy) * CELL_WIDTH_SUB_DEF;
        b = longint'(dx < 0 ? -dx : dx) * CELL_HEIGHT_SUB_DEF;
        if (a == 0 && b == 0)
            return GLYPH_FLAT;
        // slope bounds at tan(22.5) and tan(67.5), squared to stay in integers
        if ((a + b) * (a + b) < 2 * b * b)
            return GLYPH_FLAT;
        if (a > b && (a - b) * (a - b) > 2 * b * b)
            return GLYPH_UPRIGHT;
        return ((dx >= 0) == (dy >= 0)) ? GLYPH_BACKSLASH : GLYPH_SLASH;
    endfunction

    function automatic int cell_of(int sub, int size);
        int c;
        c = sub / size;
        return (c > GRID_CELLS_DEF - 1) ? GRID_CELLS_DEF - 1 : c;
    endfunction

    function automatic void walk_segment(int sx, int sy, int ex, int ey);
        int                 x, y, gx, gy, adx, nady, err, e2, n;
        logic               x_neg, y_neg, done;
        logic [GLYPH_W-1:0] slant;
        line_cell_t         c;
        slant = slant_of(ex - sx, ey - sy);
        x     = cell_of(sx, CELL_WIDTH_SUB_DEF);
        y     = cell_of(sy, CELL_HEIGHT_SUB_DEF);
        gx    = cell_of(ex, CELL_WIDTH_SUB_DEF);
        gy    = cell_of(ey, CELL_HEIGHT_SUB_DEF);
        adx   = (gx > x) ? gx - x : x - gx;
        nady  = -((gy > y) ? gy - y : y - gy);
        x_neg = !(x < gx);
        y_neg = !(y < gy);
        err   = adx + nady;
        for (n = 0; n < GRID_CELLS_DEF; n++) begin
            done      = (x == gx) && (y == gy);
            c.cell_x  = x[CELL_W-1:0];
            c.cell_y  = y[CELL_W-1:0];
            c.visible = (x < int'(area_cols)) && (y < int'(area_rows));
            c.glyph   = slant;
            c.last    = done;
            cells_due.push_back(c);
            if (done)
                break;
            e2 = 2 * err;
            if (e2 >= nady) begin
                err += nady;
                x   += x_neg ? -1 : 1;
            end
            if (e2 <= adx) begin
                err += adx;
                y   += y_neg ? -1 : 1;
            end
        end
    endfunction

    always @(posedge aclk) begin
        line_cell_t seen;
        line_cell_t want;
        if (!aresetn) begin
            cells_due.delete();
            area_cols         <= VISIBLE_COLS_RST;
            area_rows         <= VISIBLE_ROWS_RST;
            mismatch_count    <= 0;
            cells_outstanding <= 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_VISIBLE_COLS)
                    area_cols <= cfg_wdata;
                else if (cfg_index == REG_VISIBLE_ROWS)
                    area_rows <= cfg_wdata;
            end
            if (m_valid && m_ready) begin
                seen = '{m_cell_x, m_cell_y, m_visible, m_glyph, m_last};
                if (cells_due.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected cell: x=%0d y=%0d vis=%0b glyph=%0d last=%0b",
                                 seen.cell_x, seen.cell_y, seen.visible, seen.glyph,
                                 seen.last);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = cells_due.pop_front();
                    if (seen != want) begin
                        if (mismatch_count < 10) begin
                            $write("cell mismatch: expected x=%0d y=%0d vis=%0b glyph=%0d last=%0b, ",
                                   want.cell_x, want.cell_y, want.visible, want.glyph,
                                   want.last);
                            $display("got x=%0d y=%0d vis=%0b glyph=%0d last=%0b",
                                     seen.cell_x, seen.cell_y, seen.visible, seen.glyph,
                                     seen.last);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                walk_segment(int'(s_start_x_sub), int'(s_start_y_sub),
                             int'(s_end_x_sub), int'(s_end_y_sub));
            cells_outstanding <= cells_due.size();
        end
    end

endmodule

// ===== test/clipped_line_rasterizer_unit_tb.sv =====
module clipped_line_rasterizer_unit_tb;
    import clr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int CHUNK_ITEMS = 60;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = REG_VISIBLE_COLS;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [SUB_X_W-1:0]    s_start_x_sub = '0;
    logic [SUB_Y_W-1:0]    s_start_y_sub = '0;
    logic [SUB_X_W-1:0]    s_end_x_sub   = '0;
    logic [SUB_Y_W-1:0]    s_end_y_sub   = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [CELL_W-1:0]     m_cell_x;
    logic [CELL_W-1:0]     m_cell_y;
    logic                  m_visible;
    logic [GLYPH_W-1:0]    m_glyph;
    logic                  m_last;
    int                    mismatch_count;
    int                    cells_outstanding;

    int tx_idle_pct = 18;
    int rx_idle_pct = 56;
    int cycle_count = 0;

    clipped_line_rasterizer_unit dut (.*);

    line_walk_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int fit(int v, int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    // both registers are written each time; the enable drops after the second
    task automatic set_visible_area(input int cols, input int rows);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_VISIBLE_COLS;
        cfg_wdata <= cols[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_index <= REG_VISIBLE_ROWS;
        cfg_wdata <= rows[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // valid stays high after acceptance; the next request or a drain decides its level
    task automatic send_segment(input int sx, input int sy, input int ex, input int ey);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_start_x_sub <= sx[SUB_X_W-1:0];
        s_start_y_sub <= sy[SUB_Y_W-1:0];
        s_end_x_sub   <= ex[SUB_X_W-1:0];
        s_end_y_sub   <= ey[SUB_Y_W-1:0];
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_cells();
        s_valid <= 1'b0;
        do @(posedge aclk); while (cells_outstanding != 0);
    endtask

    initial begin
        int chunk, i, kind, sx, sy, ex, ey, dx, dy;
        int area_cols_list[6];
        int area_rows_list[6];
        area_cols_list = '{0, 127, 64, 1, 0, 40};
        area_rows_list = '{0, 127, 64, 1, 0, 63};
        area_cols_list[4] = $urandom_range(127);
        area_rows_list[4] = $urandom_range(127);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_visible_area(64, 63);
        send_segment(0, 0, 0, 0);           // zero length
        send_segment(127, 255, 127, 255);   // far corner, row 63 clipped
        send_segment(0, 0, 127, 255);
        send_segment(127, 255, 0, 0);
        send_segment(127, 0, 0, 255);
        send_segment(0, 255, 127, 0);
        send_segment(0, 0, 127, 0);         // horizontal
        send_segment(127, 100, 0, 100);
        send_segment(40, 0, 40, 255);       // vertical
        send_segment(40, 255, 40, 0);
        send_segment(1, 3, 0, 0);           // one cell, nonzero sub-pixel delta
        send_segment(0, 0, 1, 0);
        send_segment(0, 0, 0, 1);
        send_segment(0, 0, 100, 82);        // either side of the flat bound
        send_segment(0, 0, 100, 83);
        send_segment(0, 0, 50, 241);        // either side of the upright bound
        send_segment(0, 0, 50, 242);
        send_segment(10, 200, 30, 20);
        send_segment(126, 1, 1, 254);
        send_segment(85, 170, 42, 85);
        drain_cells();

        for (chunk = 0; chunk < 6; chunk++) begin
            case (chunk / 2)
                0: begin tx_idle_pct = 18; rx_idle_pct = 56; end
                1: begin tx_idle_pct = 56; rx_idle_pct = 18; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            set_visible_area(area_cols_list[chunk], area_rows_list[chunk]);
            for (i = 0; i < CHUNK_ITEMS; i++) begin
                kind = $urandom_range(9);
                sx   = $urandom_range(127);
                sy   = $urandom_range(255);
                case (kind)
                    0, 1, 2, 3: begin
                        ex = $urandom_range(127);
                        ey = $urandom_range(255);
                    end
                    4, 5, 6: begin
                        ex = fit(sx + $urandom_range(16) - 8, 127);
                        ey = fit(sy + $urandom_range(32) - 16, 255);
                    end
                    7: begin
                        if ($urandom_range(1)) begin
                            ex = sx;
                            ey = $urandom_range(255);
                        end else begin
                            ex = $urandom_range(127);
                            ey = sy;
                        end
                    end
                    8: begin
                        // same cell, possibly different sub-pixel
                        ex = (sx & ~1) | $urandom_range(1);
                        ey = (sy & ~3) | $urandom_range(3);
                    end
                    default: begin
                        // slopes close to the glyph bounds
                        dx = $urandom_range(1, 30);
                        dy = ($urandom_range(1) ? (dx * 828) / 1000 : (dx * 4828) / 1000)
                             + $urandom_range(2) - 1;
                        if ($urandom_range(1)) dx = -dx;
                        if ($urandom_range(1)) dy = -dy;
                        ex = fit(sx + dx, 127);
                        ey = fit(sy + dy, 255);
                    end
                endcase
                send_segment(sx, sy, ex, ey);
                if (i == CHUNK_ITEMS / 2 && chunk == 2)
                    drain_cells();
            end
            drain_cells();
        end

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && cells_outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
